[design/clslp_pkg.sv]
// shared types, register indexes and reset values for the current loop scaler
package clslp_pkg;

    localparam int ADC_BITS_DEF  = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 120;
    localparam int M_TUSER_W = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FULL_SCALE_MV  = 3'd0,
        REG_PHYS_MIN       = 3'd1,
        REG_PHYS_MAX       = 3'd2,
        REG_CURRENT_MIN_MA = 3'd3,
        REG_CURRENT_MAX_MA = 3'd4,
        REG_FILTER_TIME    = 3'd5,
        REG_SHUNT_OHMS     = 3'd6
    } cfg_reg_t;

    localparam logic [12:0]        FULL_SCALE_MV_RST  = 13'd6144;
    localparam logic signed [15:0] PHYS_MIN_RST       = 16'sd0;
    localparam logic signed [15:0] PHYS_MAX_RST       = 16'sd100;
    localparam logic [7:0]         CURRENT_MIN_MA_RST = 8'd4;
    localparam logic [7:0]         CURRENT_MAX_MA_RST = 8'd20;
    localparam logic [15:0]        FILTER_TIME_RST    = 16'd0;
    localparam logic [15:0]        SHUNT_OHMS_RST     = 16'd250;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_MAX,
        ST_MUL_MV,
        ST_LOAD_CUR,
        ST_DIV_CUR,
        ST_CUR,
        ST_MUL_MAP,
        ST_LOAD_MAP,
        ST_DIV_MAP,
        ST_PHYS,
        ST_MUL_ACC,
        ST_MUL_PHYS,
        ST_LOAD_FLT,
        ST_DIV_FLT,
        ST_FLT,
        ST_OUT
    } state_t;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

[design/current_loop_scaler_lowpass.sv]
// current loop scaler: adc code to milliamps, span mapping and first order low-pass
// the shared 2-bit-per-cycle restoring divider runs up to three divisions in turn per item
// throughput: one item at a time; s_tready is high only while the sequencer is idle
// a finished result waits in the output register while the next item is taken
// reset (aresetn low, synchronous): configuration registers to their defaults, filter state to zero
module current_loop_scaler_lowpass #(
    parameter int ADC_BITS  = clslp_pkg::ADC_BITS_DEF,
    parameter int FRAC_BITS = clslp_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [clslp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [clslp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // adc_code[15:0], elapsed_time[31:16]
    input  logic [clslp_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // filtered_value[31:0], physical_value[63:32], loop_current[93:64],
    // max_expected_mv[117:94], zero[119:118]
    output logic [clslp_pkg::M_TDATA_W-1:0]     m_tdata,
    // span_error[0]
    output logic [clslp_pkg::M_TUSER_W-1:0]     m_tuser
);

    localparam int EXT_W   = clslp_pkg::max2(ADC_BITS, 16);
    localparam int MV_W    = 13 + ADC_BITS;
    localparam int X_W     = 14 + ADC_BITS + FRAC_BITS;
    localparam int DIV1_W  = 15 + FRAC_BITS;
    localparam int DI_W    = clslp_pkg::max2(30, 9 + FRAC_BITS) + 1;
    localparam int DIV2_W  = 17 + DI_W;
    localparam int FLT_W   = 50;
    localparam int MUL_A_W = clslp_pkg::max2(clslp_pkg::max2(DI_W, 32), ADC_BITS);
    localparam int MUL_B_W = 16;
    localparam int P_W     = MUL_A_W + MUL_B_W;
    localparam int DIV_W0  = clslp_pkg::max2(clslp_pkg::max2(DIV1_W, DIV2_W), FLT_W);
    localparam int DIV_W   = DIV_W0 + (DIV_W0 % 2);
    localparam int DVS_W   = 17;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int S_W     = DIV_W + 2;

    localparam logic [29:0] CUR_POS_MAX = {1'b0, {29{1'b1}}};
    localparam logic [29:0] CUR_NEG_MIN = {1'b1, {29{1'b0}}};
    localparam logic signed [S_W-1:0] PHYS_MAX = {{(S_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [S_W-1:0] PHYS_MIN = {{(S_W-31){1'b1}}, {31{1'b0}}};

    // configuration registers
    logic [12:0]        fs_reg;
    logic signed [15:0] pmin_reg;
    logic signed [15:0] pmax_reg;
    logic [7:0]         cmin_reg;
    logic [7:0]         cmax_reg;
    logic [15:0]        ft_reg;
    logic [15:0]        shunt_reg;

    clslp_pkg::state_t state_reg, state_next;

    logic [ADC_BITS-1:0] code_mag_reg, code_mag_next;
    logic                code_neg_reg, code_neg_next;
    logic [15:0]         el_reg, el_next;
    logic [23:0]         maxexp_reg, maxexp_next;
    logic [29:0]         cur_reg, cur_next;
    logic [DI_W-1:0]     di_mag_reg, di_mag_next;
    logic                neg_reg, neg_next;
    logic [31:0]         phys_reg, phys_next;
    logic [FLT_W-1:0]    t1_reg, t1_next;
    logic [31:0]         acc_reg, acc_next;
    logic                err_reg, err_next;
    logic [P_W-1:0]      prod_reg;
    logic [DIV_W-1:0]    div_num_reg, div_num_next;
    logic [DVS_W-1:0]    div_rem_reg, div_rem_next;
    logic [DVS_W-1:0]    div_den_reg, div_den_next;
    logic [CNT_W-1:0]    div_cnt_reg, div_cnt_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [clslp_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                          m_tuser_reg, m_tuser_next;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;

    logic [EXT_W-1:0]    code_zx;
    logic [ADC_BITS-1:0] code_raw;
    logic [15:0]         shunt_eff;
    logic signed [16:0]  pdiff;
    logic [15:0]         pdiff_mag;
    logic signed [8:0]   span;
    logic [7:0]          span_mag;
    logic [31:0]         acc_mag;
    logic [31:0]         phys_mag;
    logic [DVS_W-1:0]    flt_den;
    logic                accept;
    logic                out_free;

    assign code_zx   = EXT_W'(s_tdata[15:0]);
    assign code_raw  = code_zx[ADC_BITS-1:0];
    assign shunt_eff = (shunt_reg == 16'd0) ? 16'd1 : shunt_reg;
    assign pdiff     = 17'(pmax_reg) - 17'(pmin_reg);
    assign pdiff_mag = pdiff[16] ? 16'(-pdiff) : pdiff[15:0];
    assign span      = $signed({1'b0, cmax_reg}) - $signed({1'b0, cmin_reg});
    assign span_mag  = span[8] ? 8'(-span) : span[7:0];
    assign acc_mag   = acc_reg[31] ? -acc_reg : acc_reg;
    assign phys_mag  = phys_reg[31] ? -phys_reg : phys_reg;
    assign flt_den   = DVS_W'(ft_reg) + DVS_W'(el_reg);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == clslp_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_reg    <= clslp_pkg::FULL_SCALE_MV_RST;
            pmin_reg  <= clslp_pkg::PHYS_MIN_RST;
            pmax_reg  <= clslp_pkg::PHYS_MAX_RST;
            cmin_reg  <= clslp_pkg::CURRENT_MIN_MA_RST;
            cmax_reg  <= clslp_pkg::CURRENT_MAX_MA_RST;
            ft_reg    <= clslp_pkg::FILTER_TIME_RST;
            shunt_reg <= clslp_pkg::SHUNT_OHMS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                clslp_pkg::REG_FULL_SCALE_MV:  fs_reg    <= cfg_data[12:0];
                clslp_pkg::REG_PHYS_MIN:       pmin_reg  <= cfg_data;
                clslp_pkg::REG_PHYS_MAX:       pmax_reg  <= cfg_data;
                clslp_pkg::REG_CURRENT_MIN_MA: cmin_reg  <= cfg_data[7:0];
                clslp_pkg::REG_CURRENT_MAX_MA: cmax_reg  <= cfg_data[7:0];
                clslp_pkg::REG_FILTER_TIME:    ft_reg    <= cfg_data;
                clslp_pkg::REG_SHUNT_OHMS:     shunt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            clslp_pkg::ST_IDLE:     if (accept) state_next = clslp_pkg::ST_MUL_MAX;
            clslp_pkg::ST_MUL_MAX:  state_next = clslp_pkg::ST_MUL_MV;
            clslp_pkg::ST_MUL_MV:   state_next = clslp_pkg::ST_LOAD_CUR;
            clslp_pkg::ST_LOAD_CUR: state_next = clslp_pkg::ST_DIV_CUR;
            clslp_pkg::ST_DIV_CUR:  if (div_cnt_reg == CNT_W'(1)) state_next = clslp_pkg::ST_CUR;
            clslp_pkg::ST_CUR:      state_next = (span_mag == 8'd0) ? clslp_pkg::ST_OUT
                                                                    : clslp_pkg::ST_MUL_MAP;
            clslp_pkg::ST_MUL_MAP:  state_next = clslp_pkg::ST_LOAD_MAP;
            clslp_pkg::ST_LOAD_MAP: state_next = clslp_pkg::ST_DIV_MAP;
            clslp_pkg::ST_DIV_MAP:  if (div_cnt_reg == CNT_W'(1)) state_next = clslp_pkg::ST_PHYS;
            clslp_pkg::ST_PHYS:     state_next = (el_reg == 16'd0) ? clslp_pkg::ST_OUT
                                                                   : clslp_pkg::ST_MUL_ACC;
            clslp_pkg::ST_MUL_ACC:  state_next = clslp_pkg::ST_MUL_PHYS;
            clslp_pkg::ST_MUL_PHYS: state_next = clslp_pkg::ST_LOAD_FLT;
            clslp_pkg::ST_LOAD_FLT: state_next = clslp_pkg::ST_DIV_FLT;
            clslp_pkg::ST_DIV_FLT:  if (div_cnt_reg == CNT_W'(1)) state_next = clslp_pkg::ST_FLT;
            clslp_pkg::ST_FLT:      state_next = clslp_pkg::ST_OUT;
            clslp_pkg::ST_OUT:      if (out_free) state_next = clslp_pkg::ST_IDLE;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            clslp_pkg::ST_MUL_MAX: begin
                mul_a = MUL_A_W'(cmax_reg);
                mul_b = shunt_reg;
            end
            clslp_pkg::ST_MUL_MV: begin
                mul_a = MUL_A_W'(code_mag_reg);
                mul_b = MUL_B_W'(fs_reg);
            end
            clslp_pkg::ST_MUL_MAP: begin
                mul_a = MUL_A_W'(di_mag_reg);
                mul_b = pdiff_mag;
            end
            clslp_pkg::ST_MUL_ACC: begin
                mul_a = MUL_A_W'(acc_mag);
                mul_b = ft_reg;
            end
            clslp_pkg::ST_MUL_PHYS: begin
                mul_a = MUL_A_W'(phys_mag);
                mul_b = el_reg;
            end
            default: ;
        endcase
    end

    // datapath and divider
    always_comb begin
        logic [DVS_W:0]       tmp;
        logic [DIV_W-1:0]     snum;
        logic [DVS_W-1:0]     srem;
        logic [X_W-1:0]       x1;
        logic [29:0]          cur_v;
        logic signed [DI_W-1:0] di;
        logic signed [S_W-1:0]  qs;
        logic signed [S_W-1:0]  psum;
        logic [FLT_W-1:0]     t2;
        logic [FLT_W-1:0]     fsum;
        logic [FLT_W-1:0]     fmag;

        code_mag_next = code_mag_reg;
        code_neg_next = code_neg_reg;
        el_next       = el_reg;
        maxexp_next   = maxexp_reg;
        cur_next      = cur_reg;
        di_mag_next   = di_mag_reg;
        neg_next      = neg_reg;
        phys_next     = phys_reg;
        t1_next       = t1_reg;
        acc_next      = acc_reg;
        err_next      = err_reg;
        div_num_next  = div_num_reg;
        div_rem_next  = div_rem_reg;
        div_den_next  = div_den_reg;
        div_cnt_next  = div_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        snum = div_num_reg;
        srem = div_rem_reg;
        for (int i = 0; i < 2; i++) begin
            tmp  = {srem, snum[DIV_W-1]};
            snum = {snum[DIV_W-2:0], 1'b0};
            if (tmp >= {1'b0, div_den_reg}) begin
                tmp     = tmp - {1'b0, div_den_reg};
                snum[0] = 1'b1;
            end
            srem = tmp[DVS_W-1:0];
        end

        x1 = (X_W'(prod_reg[MV_W-1:0]) << FRAC_BITS) + (X_W'(shunt_eff) << (ADC_BITS - 2));

        if (!code_neg_reg) begin
            cur_v = (div_num_reg > DIV_W'(CUR_POS_MAX)) ? CUR_POS_MAX : div_num_reg[29:0];
        end else begin
            cur_v = (div_num_reg >= DIV_W'(CUR_NEG_MIN)) ? CUR_NEG_MIN
                                                          : 30'(-div_num_reg[29:0]);
        end
        di = DI_W'($signed(cur_v)) - $signed(DI_W'(cmin_reg) << FRAC_BITS);

        qs   = neg_reg ? -$signed({2'b00, div_num_reg}) : $signed({2'b00, div_num_reg});
        psum = (S_W'(pmin_reg) <<< FRAC_BITS) + qs;

        t2   = phys_reg[31] ? FLT_W'(-FLT_W'(prod_reg)) : FLT_W'(prod_reg);
        fsum = t1_reg + t2;
        fmag = fsum[FLT_W-1] ? -fsum : fsum;

        unique case (state_reg)
            clslp_pkg::ST_IDLE: begin
                if (accept) begin
                    code_neg_next = code_raw[ADC_BITS-1];
                    code_mag_next = code_raw[ADC_BITS-1] ? -code_raw : code_raw;
                    el_next       = s_tdata[31:16];
                    err_next      = 1'b0;
                end
            end
            clslp_pkg::ST_MUL_MAX: ;
            clslp_pkg::ST_MUL_MV: begin
                maxexp_next = prod_reg[23:0];
            end
            clslp_pkg::ST_LOAD_CUR: begin
                div_num_next = DIV_W'(x1 >> (ADC_BITS - 1));
                div_rem_next = '0;
                div_den_next = DVS_W'(shunt_eff);
                div_cnt_next = CNT_W'(DIV_STEPS);
            end
            clslp_pkg::ST_DIV_CUR, clslp_pkg::ST_DIV_MAP, clslp_pkg::ST_DIV_FLT: begin
                div_num_next = snum;
                div_rem_next = srem;
                div_cnt_next = div_cnt_reg - CNT_W'(1);
            end
            clslp_pkg::ST_CUR: begin
                cur_next    = cur_v;
                di_mag_next = di[DI_W-1] ? DI_W'(-di) : DI_W'(di);
                neg_next    = di[DI_W-1] ^ pdiff[16] ^ span[8];
                if (span_mag == 8'd0) begin
                    err_next  = 1'b1;
                    phys_next = acc_reg;
                end
            end
            clslp_pkg::ST_MUL_MAP: ;
            clslp_pkg::ST_LOAD_MAP: begin
                div_num_next = DIV_W'(prod_reg) + DIV_W'(span_mag >> 1);
                div_rem_next = '0;
                div_den_next = DVS_W'(span_mag);
                div_cnt_next = CNT_W'(DIV_STEPS);
            end
            clslp_pkg::ST_PHYS: begin
                if (psum > PHYS_MAX) begin
                    phys_next = 32'h7FFF_FFFF;
                end else if (psum < PHYS_MIN) begin
                    phys_next = 32'h8000_0000;
                end else begin
                    phys_next = psum[31:0];
                end
            end
            clslp_pkg::ST_MUL_ACC: ;
            clslp_pkg::ST_MUL_PHYS: begin
                t1_next = acc_reg[31] ? FLT_W'(-FLT_W'(prod_reg)) : FLT_W'(prod_reg);
            end
            clslp_pkg::ST_LOAD_FLT: begin
                neg_next     = fsum[FLT_W-1];
                div_num_next = DIV_W'(fmag) + DIV_W'(flt_den >> 1);
                div_rem_next = '0;
                div_den_next = flt_den;
                div_cnt_next = CNT_W'(DIV_STEPS);
            end
            clslp_pkg::ST_FLT: begin
                acc_next = neg_reg ? -div_num_reg[31:0] : div_num_reg[31:0];
            end
            clslp_pkg::ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, maxexp_reg, cur_reg, phys_reg, acc_reg};
                    m_tuser_next  = err_reg;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= clslp_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            div_cnt_reg  <= '0;
            acc_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            div_cnt_reg  <= div_cnt_next;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_mag_reg <= code_mag_next;
        code_neg_reg <= code_neg_next;
        el_reg       <= el_next;
        maxexp_reg   <= maxexp_next;
        cur_reg      <= cur_next;
        di_mag_reg   <= di_mag_next;
        neg_reg      <= neg_next;
        phys_reg     <= phys_next;
        t1_reg       <= t1_next;
        err_reg      <= err_next;
        prod_reg     <= mul_a * mul_b;
        div_num_reg  <= div_num_next;
        div_rem_reg  <= div_rem_next;
        div_den_reg  <= div_den_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    a_div_cnt_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_cnt_reg != '0) |-> (state_reg == clslp_pkg::ST_DIV_CUR ||
                                 state_reg == clslp_pkg::ST_DIV_MAP ||
                                 state_reg == clslp_pkg::ST_DIV_FLT))
        else $error("divider count running outside a divide state");

    a_acc_only_in_flt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != clslp_pkg::ST_FLT) |=> $stable(acc_reg))
        else $error("filter state changed outside the filter update");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready right after an item was taken");

    a_span_err_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[63:32] == m_tdata[31:0]))
        else $error("span error result does not report the held filter value");

endmodule

[bench/current_loop_scaler_lowpass_tb.sv]
// self-checking bench for the current loop scaler with first order low-pass
module current_loop_scaler_lowpass_tb;

    localparam int ADC_BITS    = clslp_pkg::ADC_BITS_DEF;
    localparam int FRAC_BITS   = clslp_pkg::FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 100;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        logic [31:0] filtered;
        logic [31:0] physical;
        logic [29:0] current;
        logic [23:0] peak_mv;
        logic        span_err;
    } reading_t;

    typedef enum {RX_FLOW, RX_COIN, RX_EVERY_FOURTH, RX_SPARSE} rx_pattern_t;

    class reading_board;
        reading_t           pending[$];
        int                 failures;
        logic [12:0]        full_scale;
        logic signed [15:0] phys_lo;
        logic signed [15:0] phys_hi;
        logic [7:0]         ma_lo;
        logic [7:0]         ma_hi;
        logic [15:0]        tau;
        logic [15:0]        shunt;
        longint             accum;

        function new();
            full_scale = clslp_pkg::FULL_SCALE_MV_RST;
            phys_lo    = clslp_pkg::PHYS_MIN_RST;
            phys_hi    = clslp_pkg::PHYS_MAX_RST;
            ma_lo      = clslp_pkg::CURRENT_MIN_MA_RST;
            ma_hi      = clslp_pkg::CURRENT_MAX_MA_RST;
            tau        = clslp_pkg::FILTER_TIME_RST;
            shunt      = clslp_pkg::SHUNT_OHMS_RST;
            accum      = 0;
            failures   = 0;
        endfunction

        function void set_reg(clslp_pkg::cfg_reg_t r, logic [15:0] v);
            case (r)
                clslp_pkg::REG_FULL_SCALE_MV:  full_scale = v[12:0];
                clslp_pkg::REG_PHYS_MIN:       phys_lo = v;
                clslp_pkg::REG_PHYS_MAX:       phys_hi = v;
                clslp_pkg::REG_CURRENT_MIN_MA: ma_lo = v[7:0];
                clslp_pkg::REG_CURRENT_MAX_MA: ma_hi = v[7:0];
                clslp_pkg::REG_FILTER_TIME:    tau = v;
                clslp_pkg::REG_SHUNT_OHMS:     shunt = v;
                default: ;
            endcase
        endfunction

        // round to nearest, ties away from zero, d > 0
        static function longint div_near(longint n, longint d);
            longint m;
            m = (n < 0) ? -n : n;
            m = (m + d / 2) / d;
            return (n < 0) ? -m : m;
        endfunction

        function void note_sample(logic [15:0] adc, logic [15:0] el);
            longint   one, code, elapsed, ohms, lo, hi, span, cur, phys, q, mv;
            reading_t r;
            one     = longint'(1) << FRAC_BITS;
            code    = longint'($signed(adc));
            elapsed = longint'(el);
            ohms    = (shunt == 0) ? longint'(1) : longint'(shunt);
            lo      = longint'(phys_lo);
            hi      = longint'(phys_hi);
            span    = longint'(ma_hi) - longint'(ma_lo);
            cur = div_near(longint'(full_scale) * code * one,
                           ohms * (longint'(1) << (ADC_BITS - 1)));
            if (cur < -(longint'(1) << 29))
                cur = -(longint'(1) << 29);
            if (cur > (longint'(1) << 29) - 1)
                cur = (longint'(1) << 29) - 1;
            r.span_err = (span == 0);
            if (span == 0) begin
                phys = accum;
            end else begin
                if (span < 0)
                    q = -div_near((hi - lo) * (cur - longint'(ma_lo) * one), -span);
                else
                    q = div_near((hi - lo) * (cur - longint'(ma_lo) * one), span);
                phys = lo * one + q;
                if (phys < -(longint'(1) << 31))
                    phys = -(longint'(1) << 31);
                if (phys > (longint'(1) << 31) - 1)
                    phys = (longint'(1) << 31) - 1;
                if (elapsed != 0)
                    accum = div_near(accum * longint'(tau) + phys * elapsed,
                                     longint'(tau) + elapsed);
            end
            mv         = longint'(ma_hi) * longint'(shunt);
            r.filtered = accum[31:0];
            r.physical = phys[31:0];
            r.current  = cur[29:0];
            r.peak_mv  = mv[23:0];
            pending.push_back(r);
        endfunction

        function void check_reading(logic [clslp_pkg::M_TDATA_W-1:0] data,
                                    logic [clslp_pkg::M_TUSER_W-1:0] user);
            reading_t got, want;
            got.filtered = data[31:0];
            got.physical = data[63:32];
            got.current  = data[93:64];
            got.peak_mv  = data[117:94];
            got.span_err = user[0];
            if (pending.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: filt=%0d phys=%0d cur=%0d mv=%0d err=%0d",
                             $signed(got.filtered), $signed(got.physical),
                             $signed(got.current), got.peak_mv, got.span_err);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: exp filt=%0d phys=%0d cur=%0d mv=%0d err=%0d",
                             $signed(want.filtered), $signed(want.physical),
                             $signed(want.current), want.peak_mv, want.span_err,
                             " | got filt=%0d phys=%0d cur=%0d mv=%0d err=%0d",
                             $signed(got.filtered), $signed(got.physical),
                             $signed(got.current), got.peak_mv, got.span_err);
            end
        endfunction
    endclass

    logic                                aclk;
    logic                                aresetn;
    logic                                cfg_wr_en;
    clslp_pkg::cfg_reg_t                 cfg_index;
    logic [clslp_pkg::CFG_DATA_W-1:0]    cfg_data;
    logic                                s_tvalid;
    logic                                s_tready;
    // adc_code[15:0], elapsed_time[31:16]
    logic [clslp_pkg::S_TDATA_W-1:0]     s_tdata;
    logic                                m_tvalid;
    logic                                m_tready;
    // filtered_value[31:0], physical_value[63:32], loop_current[93:64],
    // max_expected_mv[117:94], zero[119:118]
    logic [clslp_pkg::M_TDATA_W-1:0]     m_tdata;
    // span_error[0]
    logic [clslp_pkg::M_TUSER_W-1:0]     m_tuser;

    reading_board sb;
    int           burst_left = 0;
    int           cycles = 0;
    int           rx_count = 0;
    rx_pattern_t  rx_mode = RX_FLOW;

    current_loop_scaler_lowpass #(
        .ADC_BITS  (ADC_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: checks taken readings and switches between stall patterns at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_reading(m_tdata, m_tuser);
        if (rx_count == 0) begin
            rx_mode  <= rx_pattern_t'($urandom_range(0, 3));
            rx_count <= $urandom_range(20, 200);
        end else begin
            rx_count <= rx_count - 1;
        end
        case (rx_mode)
            RX_FLOW:         m_tready <= 1'b1;
            RX_COIN:         m_tready <= 1'($urandom_range(0, 1));
            RX_EVERY_FOURTH: m_tready <= (rx_count[1:0] == 2'd0);
            default:         m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_sample(input logic [15:0] adc, input logic [15:0] el);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {el, adc};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(adc, el);
        burst_left--;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input clslp_pkg::cfg_reg_t r, input logic [15:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge aclk);
        sb.set_reg(r, v);
    endtask

    task automatic apply_setting(input logic [12:0] fs, input logic [15:0] lo,
                                 input logic [15:0] hi, input logic [7:0] ma_lo,
                                 input logic [7:0] ma_hi, input logic [15:0] tau,
                                 input logic [15:0] ohms);
        write_reg(clslp_pkg::REG_FULL_SCALE_MV, {3'b000, fs});
        write_reg(clslp_pkg::REG_PHYS_MIN, lo);
        write_reg(clslp_pkg::REG_PHYS_MAX, hi);
        write_reg(clslp_pkg::REG_CURRENT_MIN_MA, {8'h00, ma_lo});
        write_reg(clslp_pkg::REG_CURRENT_MAX_MA, {8'h00, ma_hi});
        write_reg(clslp_pkg::REG_FILTER_TIME, tau);
        write_reg(clslp_pkg::REG_SHUNT_OHMS, ohms);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_setting();
        logic [12:0] fs;
        logic [15:0] lo, hi, tau, ohms;
        logic [7:0]  ma_lo, ma_hi;
        case ($urandom_range(0, 5))
            0:       fs = 13'd0;
            1:       fs = 13'h1FFF;
            default: fs = 13'($urandom_range(1, 8191));
        endcase
        lo = 16'($urandom);
        hi = 16'($urandom);
        if ($urandom_range(0, 1)) begin
            lo = 16'($urandom_range(0, 200) - 100);
            hi = 16'(lo + $urandom_range(1, 2000));
        end
        case ($urandom_range(0, 5))
            0: begin
                ma_lo = 8'($urandom);
                ma_hi = 8'($urandom);
            end
            1: begin
                ma_lo = 8'($urandom);
                ma_hi = ma_lo;
            end
            2: begin
                ma_hi = 8'($urandom_range(0, 10));
                ma_lo = 8'(ma_hi + $urandom_range(1, 30));
            end
            default: begin
                ma_lo = 8'($urandom_range(0, 10));
                ma_hi = 8'(ma_lo + $urandom_range(1, 30));
            end
        endcase
        case ($urandom_range(0, 4))
            0:       tau = 16'd0;
            1:       tau = 16'hFFFF;
            2:       tau = 16'($urandom_range(1, 20));
            default: tau = 16'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       ohms = 16'd0;
            1:       ohms = 16'd1;
            2:       ohms = 16'hFFFF;
            default: ohms = 16'($urandom_range(50, 500));
        endcase
        apply_setting(fs, lo, hi, ma_lo, ma_hi, tau, ohms);
    endtask

    initial begin
        logic [15:0] adc, el;
        sb = new();
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= clslp_pkg::REG_FULL_SCALE_MV;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults, filter passes straight through, zero elapsed holds
        send_sample(16'h0000, 16'h0001);
        send_sample(16'h7FFF, 16'h0001);
        send_sample(16'h8000, 16'hFFFF);
        send_sample(16'h0001, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(16'h5555, 16'hAAAA);
        send_sample(16'hAAAA, 16'h5555);
        drain();

        // widest span and smallest shunt: physical value saturates
        apply_setting(13'h1FFF, 16'h8000, 16'h7FFF, 8'd0, 8'd255, 16'hFFFF, 16'd1);
        send_sample(16'h7FFF, 16'hFFFF);
        send_sample(16'h8000, 16'h0001);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'd12345, 16'd100);
        drain();

        // empty span with zero shunt and zero full scale
        apply_setting(13'd0, 16'd100, 16'(-100), 8'd10, 8'd10, 16'd5, 16'd0);
        send_sample(16'h7FFF, 16'd3);
        send_sample(16'h8000, 16'd0);
        send_sample(16'd100, 16'd7);
        drain();

        // reversed current span
        apply_setting(13'd4096, 16'(-500), 16'd1500, 8'd20, 8'd4, 16'd1000, 16'd100);
        send_sample(16'h7FFF, 16'd10);
        send_sample(16'hFFFF, 16'd500);
        send_sample(16'd16384, 16'd0);
        send_sample(16'(-20000), 16'hFFFF);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            random_setting();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 5))
                    0: adc = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                    1: adc = 16'($urandom_range(0, 4000) - 2000);
                    default: adc = 16'($urandom);
                endcase
                case ($urandom_range(0, 7))
                    0:       el = 16'd0;
                    1:       el = 16'hFFFF;
                    2, 3:    el = 16'($urandom_range(1, 50));
                    default: el = 16'($urandom);
                endcase
                send_sample(adc, el);
            end
            drain();
        end

        if (sb.failures == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
design/clslp_pkg.sv
design/current_loop_scaler_lowpass.sv
bench/current_loop_scaler_lowpass_tb.sv
